[rtl/sbfd_pkg.sv]
// Shared constants, codes and beat types of the bus frame decoder.
package sbfd_pkg;

    // Frame layout
    localparam int FRAME_BYTES   = 25;
    localparam int CHANNEL_COUNT = 16;
    localparam int CHAN_BITS     = 11;
    localparam int STORE_DEPTH   = FRAME_BYTES - 1;
    localparam int DATA_BYTES    = CHANNEL_COUNT * CHAN_BITS / 8;
    localparam int DATA_BITS     = DATA_BYTES * 8;
    localparam int FLAG_POS      = DATA_BYTES + 1;
    localparam int FAILSAFE_POS  = 4;
    localparam int LOST_POS      = 5;

    localparam logic [7:0] START_MARK = 8'h0F;
    localparam logic [7:0] END_MARK   = 8'h00;

    // Steering and throttle thresholds
    localparam int STEER_NEUTRAL    = 874;
    localparam int THROTTLE_NEUTRAL = 488;
    localparam int DEAD_BAND        = 50;

    // Speed divider: magnitude of the product of an 11-bit and an 8-bit span
    localparam int DIV_BITS = 19;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIMEOUT_LIMIT   = 3'd0,
        REG_THROTTLE_CENTER = 3'd1,
        REG_THROTTLE_MAX    = 3'd2,
        REG_SPEED_LOW       = 3'd3,
        REG_SPEED_HIGH      = 3'd4
    } t_reg_index;

    typedef enum logic [1:0] {
        MOVE_HALT  = 2'd0,
        MOVE_AHEAD = 2'd1,
        MOVE_LEFT  = 2'd2,
        MOVE_RIGHT = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_COLLECT,
        ST_DECIDE,
        ST_DIV,
        ST_SPEED,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in_beat;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic        failsafe_flag;
        logic        lost_frame_flag;
        t_command    command;
        logic [7:0]  speed;
        logic        last;
    } t_out_beat;

    // Controller to datapath
    typedef struct packed {
        logic gap_clear;
        logic gap_inc;
        logic pos_clear;
        logic pos_set;
        logic store;
        logic decide_load;
        logic hold_low;
        logic mult_load;
        logic div_step;
        logic speed_load;
        logic emit_next;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic gap_over;
        logic is_start;
        logic is_end;
        logic pos_last;
        logic forward;
        logic den_zero;
        logic div_done;
        logic emit_last;
    } t_dp_stat;

endpackage

[rtl/sbfd_stream_if.sv]
// Valid/ready stream interface that carries one beat of a given type.
interface sbfd_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/sbfd_ctrl.sv]
// Controller state machine of the bus frame decoder.
module sbfd_ctrl
    import sbfd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_HUNT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_stat.gap_over) begin
                        o_cmd.gap_clear = 1'b1;
                        o_cmd.pos_clear = 1'b1;
                    end else if (i_stat.is_start) begin
                        o_cmd.gap_clear = 1'b1;
                        o_cmd.pos_set   = 1'b1;
                        n_state         = ST_COLLECT;
                    end else begin
                        o_cmd.gap_inc = 1'b1;
                    end
                end
            end
            ST_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_stat.gap_over) begin
                        o_cmd.gap_clear = 1'b1;
                        o_cmd.pos_clear = 1'b1;
                        n_state         = ST_HUNT;
                    end else if (!i_stat.pos_last) begin
                        o_cmd.store   = 1'b1;
                        o_cmd.gap_inc = 1'b1;
                    end else begin
                        // Closing byte: the frame ends either way.
                        o_cmd.gap_clear = 1'b1;
                        o_cmd.pos_clear = 1'b1;
                        n_state = i_stat.is_end ? ST_DECIDE : ST_HUNT;
                    end
                end
            end
            ST_DECIDE: begin
                o_cmd.decide_load = 1'b1;
                if (i_stat.forward && i_stat.den_zero) begin
                    o_cmd.hold_low = 1'b1;
                    n_state        = ST_EMIT;
                end else if (i_stat.forward) begin
                    o_cmd.mult_load = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = ST_SPEED;
                end
            end
            ST_SPEED: begin
                o_cmd.speed_load = 1'b1;
                n_state          = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_next = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = ST_HUNT;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

endmodule

[rtl/sbfd_datapath.sv]
// Datapath of the bus frame decoder: counters, frame bits, speed math, result beat.
module sbfd_datapath
    import sbfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [7:0]             i_rx_byte,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output t_out_beat              o_beat
);

    // Configuration registers
    logic [7:0]  r_timeout_limit;
    logic [10:0] r_throttle_center;
    logic [10:0] r_throttle_max;
    logic [7:0]  r_speed_low;
    logic [7:0]  r_speed_high;

    // Control counters and held state
    logic [8:0] r_gap;
    logic [4:0] r_pos;
    logic [7:0] r_held;
    logic [3:0] r_emit_idx;

    // Payload registers
    logic [DATA_BITS-1:0] r_bits;
    logic [7:0]           r_flags;
    t_command             r_cmd;
    logic [DIV_BITS-1:0]  r_quot;
    logic [11:0]          r_rem;
    logic [10:0]          r_den;
    logic                 r_neg;
    logic [4:0]           r_div_cnt;

    logic [8:0]         gap_next;
    logic [10:0]        ch0;
    logic [10:0]        ch2;
    logic               failsafe;
    t_command           steer;
    logic [10:0]        v_lo;
    logic [10:0]        v_clamp;
    logic signed [11:0] dv;
    logic signed [8:0]  ds;
    logic signed [20:0] dv_ext;
    logic signed [20:0] ds_ext;
    logic signed [20:0] prod;
    logic signed [20:0] prod_neg;
    logic [DIV_BITS-1:0] num_mag;
    logic signed [11:0] den;
    logic signed [11:0] den_neg;
    logic [10:0]        den_mag;
    logic [11:0]        shifted;
    logic [11:0]        diff;
    logic               ge;
    logic [DIV_BITS:0]  q_signed;
    logic [20:0]        sum;
    logic [7:0]         speed_sat;

    // Byte tracking status
    assign gap_next        = r_gap + 9'd1;
    assign o_stat.gap_over = gap_next > {1'b0, r_timeout_limit};
    assign o_stat.is_start = i_rx_byte == START_MARK;
    assign o_stat.is_end   = i_rx_byte == END_MARK;
    assign o_stat.pos_last = r_pos == 5'(STORE_DEPTH);

    // Steering decision from channels 0 and 2
    assign ch0      = r_bits[CHAN_BITS-1:0];
    assign ch2      = r_bits[2*CHAN_BITS +: CHAN_BITS];
    assign failsafe = r_flags[FAILSAFE_POS];
    assign o_stat.forward = !failsafe && (ch2 > 11'(THROTTLE_NEUTRAL + DEAD_BAND));

    always_comb begin
        if (ch0 < 11'(STEER_NEUTRAL - DEAD_BAND)) begin
            steer = MOVE_LEFT;
        end else if (ch0 > 11'(STEER_NEUTRAL + DEAD_BAND)) begin
            steer = MOVE_RIGHT;
        end else begin
            steer = MOVE_AHEAD;
        end
    end

    // Throttle clamp, span product and divisor
    assign v_lo     = (ch2 < r_throttle_center) ? r_throttle_center : ch2;
    assign v_clamp  = (v_lo > r_throttle_max) ? r_throttle_max : v_lo;
    assign dv       = $signed({1'b0, v_clamp}) - $signed({1'b0, r_throttle_center});
    assign ds       = $signed({1'b0, r_speed_high}) - $signed({1'b0, r_speed_low});
    assign dv_ext   = {{9{dv[11]}}, dv};
    assign ds_ext   = {{12{ds[8]}}, ds};
    assign prod     = dv_ext * ds_ext;
    assign prod_neg = -prod;
    assign num_mag  = prod[20] ? prod_neg[DIV_BITS-1:0] : prod[DIV_BITS-1:0];
    assign den      = $signed({1'b0, r_throttle_max}) - $signed({1'b0, r_throttle_center});
    assign den_neg  = -den;
    assign den_mag  = den[11] ? den_neg[10:0] : den[10:0];
    assign o_stat.den_zero = den == 12'sd0;

    // One restoring division step per cycle
    assign shifted = {r_rem[10:0], r_quot[DIV_BITS-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = shifted >= {1'b0, r_den};
    assign o_stat.div_done = r_div_cnt == 5'(DIV_BITS - 1);

    // Signed quotient added to the low speed, saturated to a byte
    always_comb begin
        q_signed = r_neg ? (-{1'b0, r_quot}) : {1'b0, r_quot};
        sum      = {13'd0, r_speed_low} + {q_signed[DIV_BITS], q_signed};
        if (sum[20]) begin
            speed_sat = 8'd0;
        end else if (sum > 21'd255) begin
            speed_sat = 8'd255;
        end else begin
            speed_sat = sum[7:0];
        end
    end

    // Result beat
    assign o_stat.emit_last       = r_emit_idx == 4'(CHANNEL_COUNT - 1);
    assign o_beat.channel_index   = r_emit_idx;
    assign o_beat.channel_value   = r_bits[CHAN_BITS-1:0];
    assign o_beat.failsafe_flag   = r_flags[FAILSAFE_POS];
    assign o_beat.lost_frame_flag = r_flags[LOST_POS];
    assign o_beat.command         = r_cmd;
    assign o_beat.speed           = r_held;
    assign o_beat.last            = o_stat.emit_last;

    // Registers that reset: configuration, counters, held speed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit   <= 8'd50;
            r_throttle_center <= 11'd488;
            r_throttle_max    <= 11'd1811;
            r_speed_low       <= 8'd2;
            r_speed_high      <= 8'd10;
            r_gap             <= '0;
            r_pos             <= '0;
            r_held            <= '0;
            r_emit_idx        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg_index'(i_cfg_index))
                    REG_TIMEOUT_LIMIT:   r_timeout_limit   <= i_cfg_data[7:0];
                    REG_THROTTLE_CENTER: r_throttle_center <= i_cfg_data[10:0];
                    REG_THROTTLE_MAX:    r_throttle_max    <= i_cfg_data[10:0];
                    REG_SPEED_LOW:       r_speed_low       <= i_cfg_data[7:0];
                    REG_SPEED_HIGH:      r_speed_high      <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.gap_clear) begin
                r_gap <= '0;
            end else if (i_cmd.gap_inc) begin
                r_gap <= gap_next;
            end
            if (i_cmd.pos_clear) begin
                r_pos <= '0;
            end else if (i_cmd.pos_set) begin
                r_pos <= 5'd1;
            end else if (i_cmd.store) begin
                r_pos <= r_pos + 5'd1;
            end
            if (i_cmd.hold_low) begin
                r_held <= r_speed_low;
            end else if (i_cmd.speed_load) begin
                r_held <= speed_sat;
            end
            if (i_cmd.decide_load) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit_next) begin
                r_emit_idx <= r_emit_idx + 4'd1;
            end
        end
    end

    // Payload registers: frame bits, flag byte, command, divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            if (r_pos == 5'(FLAG_POS)) begin
                r_flags <= i_rx_byte;
            end else begin
                r_bits <= {i_rx_byte, r_bits[DATA_BITS-1:8]};
            end
        end else if (i_cmd.emit_next) begin
            r_bits <= r_bits >> CHAN_BITS;
        end
        if (i_cmd.decide_load) begin
            r_cmd <= o_stat.forward ? steer : MOVE_HALT;
        end
        if (i_cmd.mult_load) begin
            r_quot    <= num_mag;
            r_rem     <= '0;
            r_den     <= den_mag;
            r_neg     <= prod[20] ^ den[11];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_quot    <= {r_quot[DIV_BITS-2:0], ge};
            r_rem     <= ge ? diff : shifted;
            r_div_cnt <= r_div_cnt + 5'd1;
        end
    end

endmodule

[rtl/sbus_frame_decoder.sv]
// Top level of the bus frame decoder: controller, datapath and stream ports.
//
// Received bytes enter one per beat on i_in (payload rx_byte). The block hunts
// for the start byte, collects a 25-byte frame and, when the closing byte is
// zero, sends 16 result beats on o_out, one per channel in order, with last
// set on channel 15. Frames with a bad closing byte or a gap timeout give
// nothing. The user must write configuration registers on i_cfg_we only while
// idle; the block does not enforce it. Input bytes are taken one per cycle
// while a frame is being collected. After a good closing byte, input stays
// stalled until the last result beat is taken. The first result follows the
// closing byte through the decide state when the command is not forward or
// the throttle limits are equal, and through the decide, divide and speed
// states otherwise: the speed comes from a restoring divider that resolves
// one of 19 quotient bits per cycle. Results then leave at one per cycle; a
// stalled receiver simply holds the current result beat and delays the rest.
// Synchronous reset restores the register defaults, clears the held speed
// and returns the block to the hunt for a start byte.
module sbus_frame_decoder
    import sbfd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    sbfd_stream_if.sink            i_in,
    sbfd_stream_if.source          o_out,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd   dp_cmd;
    t_dp_stat  dp_stat;
    t_in_beat  in_beat;
    t_out_beat out_beat;

    assign in_beat    = i_in.data;
    assign o_out.data = out_beat;

    // Sequencing of bytes, speed computation and result beats
    sbfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (dp_cmd)
    );

    // Counters, frame store, divider and configuration
    sbfd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (in_beat.rx_byte),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_beat      (out_beat)
    );

endmodule
